// File: hw/rtl/acs_pkg.sv
// Package for the AES-CFB sector cipher: payload structs, key size codes,
// AES byte functions and the S-box. Used by every module of the block.
`timescale 1ns / 1ps

package acs_pkg;

    localparam int SECTOR_BYTES_DEF = 512;
    localparam int RK_WORDS = 60;   // 32-bit round key words for 14 rounds
    localparam int KEY_WORDS = 8;   // 32-bit words of the largest key

    // key_length register codes
    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [1:0] KLEN_256 = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_KLEN   = 3'd4;
    localparam logic [2:0] REG_NONCE  = 3'd5;
    localparam logic [2:0] REG_OFFSET = 3'd6;

    typedef struct packed {
        logic        mode;
        logic        start_req;
        logic [63:0] data_lo;
        logic [63:0] data_hi;
    } t_in_req;

    typedef struct packed {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
    } t_out_req;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // S-box on each byte of a word, byte 0 in the low bits
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        logic [31:0] r;
        for (int b = 0; b < 4; b++) begin
            r[8*b +: 8] = SBOX[w[8*b +: 8]];
        end
        sub_word = r;
    endfunction

    // SubBytes then ShiftRows; byte i of the state at bits 8i+7:8i
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                r[8*(i+4*c) +: 8] = SBOX[s[8*(i+4*((c+i)%4)) +: 8]];
            end
        end
        sub_shift = r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] r;
        logic [7:0]   a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = s[8*(4*c)   +: 8];
            a1  = s[8*(4*c+1) +: 8];
            a2  = s[8*(4*c+2) +: 8];
            a3  = s[8*(4*c+3) +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            r[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            r[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            r[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            r[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix_columns = r;
    endfunction

endpackage

// File: hw/rtl/aes_cfb_sector_cipher.sv
// AES-CFB128 sector cipher top level: input register, unrolled AES, result
// register. One block per cycle sustained while the output is not stalled
// and no key schedule runs, the AES being combinational over the feedback
// loop. A key or key length write, and reset, stall input requests while
// the key schedule runs. Depends on acs_pkg, acs_key_expand, acs_aes_core.
`timescale 1ns / 1ps

module aes_cfb_sector_cipher #(
    parameter int SECTOR_BYTES = acs_pkg::SECTOR_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  acs_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output acs_pkg::t_out_req o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int SB_RAW = SECTOR_BYTES / 16;
    localparam int SECT_BLOCKS = (SB_RAW > 0) ? SB_RAW : 1;
    localparam int CNT_W = $clog2(SECT_BLOCKS + 1);

    logic [3:0][63:0] r_key;
    logic [1:0]  r_klen;
    logic [63:0] r_nonce, r_offset, r_start_off;
    logic [63:0] r_fb_lo, r_fb_hi;
    logic [CNT_W-1:0] r_blocks;
    logic        r_in_valid, r_out_valid, r_kx_restart;
    acs_pkg::t_in_req  r_in;
    acs_pkg::t_out_req r_out;

    logic        wr_en, in_accept, advance, restart, kx_busy;
    logic [2:0]  reg_idx;
    logic [127:0] fb_use, keystream, result;
    logic [acs_pkg::RK_WORDS-1:0][31:0] round_keys;

    // configuration port
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_klen       <= acs_pkg::KLEN_128;
            r_nonce      <= 64'd0;
            r_start_off  <= 64'd0;
            r_kx_restart <= 1'b0;
        end else begin
            r_kx_restart <= 1'b0;
            if (wr_en) begin
                case (reg_idx)
                    acs_pkg::REG_KEY0, acs_pkg::REG_KEY1,
                    acs_pkg::REG_KEY2, acs_pkg::REG_KEY3: begin
                        r_key[reg_idx[1:0]] <= pwdata;
                        r_kx_restart <= 1'b1;
                    end
                    acs_pkg::REG_KLEN: begin
                        r_klen <= pwdata[1:0];
                        r_kx_restart <= 1'b1;
                    end
                    acs_pkg::REG_NONCE:  r_nonce <= pwdata;
                    acs_pkg::REG_OFFSET: r_start_off <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (reg_idx)
            acs_pkg::REG_KEY0:   prdata = r_key[0];
            acs_pkg::REG_KEY1:   prdata = r_key[1];
            acs_pkg::REG_KEY2:   prdata = r_key[2];
            acs_pkg::REG_KEY3:   prdata = r_key[3];
            acs_pkg::REG_KLEN:   prdata = {62'd0, r_klen};
            acs_pkg::REG_NONCE:  prdata = r_nonce;
            acs_pkg::REG_OFFSET: prdata = r_start_off;
            default:             prdata = 64'd0;
        endcase
    end

    acs_key_expand u_key_expand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (r_kx_restart),
        .i_key_length (r_klen),
        .i_key        (r_key),
        .o_busy       (kx_busy),
        .o_round_keys (round_keys)
    );

    // handshake: input register feeds the result register
    assign advance    = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = kx_busy | r_kx_restart | (r_in_valid & ~advance);
    assign in_accept  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept | (r_in_valid & ~advance);
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // feedback restart at buffer start or sector end
    assign restart   = r_in.start_req | (r_blocks >= CNT_W'(SECT_BLOCKS));
    assign fb_use    = restart ? {r_offset, r_nonce} : {r_fb_hi, r_fb_lo};

    acs_aes_core u_aes (
        .i_key_length (r_klen),
        .i_round_keys (round_keys),
        .i_block      (fb_use),
        .o_block      (keystream)
    );

    assign result = {r_in.data_hi, r_in.data_lo} ^ keystream;

    // CFB state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_lo  <= 64'd0;
            r_fb_hi  <= 64'd0;
            r_offset <= 64'd0;
            r_blocks <= '0;
        end else if (wr_en && reg_idx == acs_pkg::REG_OFFSET) begin
            r_offset <= pwdata;
        end else if (advance) begin
            if (r_in.mode) begin
                r_fb_lo <= r_in.data_lo;
                r_fb_hi <= r_in.data_hi;
            end else begin
                r_fb_lo <= result[63:0];
                r_fb_hi <= result[127:64];
            end
            if (restart) begin
                r_offset <= r_offset + 64'(SECTOR_BYTES);
                r_blocks <= CNT_W'(1);
            end else begin
                r_blocks <= r_blocks + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.result_lo <= result[63:0];
            r_out.result_hi <= result[127:64];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/acs_key_expand.sv
// AES key schedule sequencer: one round key word per cycle into a word file.
// Depends on acs_pkg (S-box, key size codes).
`timescale 1ns / 1ps

module acs_key_expand (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_restart,
    input  logic [1:0]                            i_key_length,
    input  logic [acs_pkg::KEY_WORDS-1:0][31:0]   i_key,
    output logic                                  o_busy,
    output logic [acs_pkg::RK_WORDS-1:0][31:0]    o_round_keys
);

    logic        r_load, r_run;
    logic [5:0]  r_idx;       // word being produced
    logic [2:0]  r_pos;       // r_idx modulo nk
    logic [7:0]  r_rcon;
    logic [7:0][31:0] r_win;  // last eight words, [7] newest
    logic [acs_pkg::RK_WORDS-1:0][31:0] r_rk;

    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [31:0] t_word, new_word, old_word;

    // words per key and last word index for the selected key size
    always_comb begin
        case (i_key_length)
            acs_pkg::KLEN_128: begin
                nk = 4'd4;
                last_idx = 6'd43;
            end
            acs_pkg::KLEN_256: begin
                nk = 4'd8;
                last_idx = 6'd59;
            end
            default: begin
                nk = 4'd6;
                last_idx = 6'd51;
            end
        endcase
    end

    // next schedule word from the window
    always_comb begin
        t_word = r_win[7];
        if (r_pos == 3'd0) begin
            t_word = acs_pkg::sub_word({r_win[7][7:0], r_win[7][31:8]})
                     ^ {24'd0, r_rcon};
        end else if (nk == 4'd8 && r_pos == 3'd4) begin
            t_word = acs_pkg::sub_word(r_win[7]);
        end
        old_word = r_win[3'(4'd8 - nk)];
        new_word = old_word ^ t_word;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b1;
            r_run  <= 1'b0;
        end else if (i_restart) begin
            r_load <= 1'b1;
            r_run  <= 1'b0;
        end else if (r_load) begin
            r_load <= 1'b0;
            r_run  <= 1'b1;
        end else if (r_run && r_idx == last_idx) begin
            r_run <= 1'b0;
        end
    end

    // schedule datapath
    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_idx  <= 6'(nk);
            r_pos  <= 3'd0;
            r_rcon <= 8'h01;
            for (int k = 0; k < 8; k++) begin
                r_win[k] <= (4'(k) >= 4'd8 - nk) ? i_key[3'(4'(k) + nk - 4'd8)] : 32'd0;
                r_rk[k]  <= i_key[k];
            end
        end else if (r_run) begin
            r_idx <= r_idx + 6'd1;
            r_pos <= (4'(r_pos) == nk - 4'd1) ? 3'd0 : r_pos + 3'd1;
            if (r_pos == 3'd0) begin
                r_rcon <= acs_pkg::xtime(r_rcon);
            end
            for (int k = 0; k < 7; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[7] <= new_word;
            for (int k = 0; k < acs_pkg::RK_WORDS; k++) begin
                if (r_idx == 6'(k)) begin
                    r_rk[k] <= new_word;
                end
            end
        end
    end

    assign o_busy = r_load | r_run;
    assign o_round_keys = r_rk;

endmodule

// File: hw/rtl/acs_aes_core.sv
// Unrolled AES-128/192/256 block encryption, combinational.
// Depends on acs_pkg (round functions, key size codes).
`timescale 1ns / 1ps

module acs_aes_core (
    input  logic [1:0]                            i_key_length,
    input  logic [acs_pkg::RK_WORDS-1:0][31:0]    i_round_keys,
    input  logic [127:0]                          i_block,
    output logic [127:0]                          o_block
);

    logic [14:0][127:0] st;   // state after r full rounds
    logic [127:0] fin10, fin12, fin14;

    assign st[0] = i_block ^ i_round_keys[3:0];

    for (genvar r = 1; r < 14; r++) begin : g_round
        assign st[r] = acs_pkg::mix_columns(acs_pkg::sub_shift(st[r-1]))
                       ^ i_round_keys[4*r+3 -: 4];
    end
    assign st[14] = 128'd0;

    // last rounds skip MixColumns
    assign fin10 = acs_pkg::sub_shift(st[9])  ^ i_round_keys[43:40];
    assign fin12 = acs_pkg::sub_shift(st[11]) ^ i_round_keys[51:48];
    assign fin14 = acs_pkg::sub_shift(st[13]) ^ i_round_keys[59:56] ^ st[14];

    always_comb begin
        case (i_key_length)
            acs_pkg::KLEN_128: o_block = fin10;
            acs_pkg::KLEN_256: o_block = fin14;
            default:           o_block = fin12;
        endcase
    end

endmodule

// File: tb/sv/tb_cfb_checker.sv
// Checker for the AES-CFB sector cipher: watches the APB port and both request
// channels, predicts each result and compares it. Depends on acs_pkg.
`timescale 1ns / 1ps

module tb_cfb_checker #(
    parameter int SECTOR_BYTES = acs_pkg::SECTOR_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  acs_pkg::t_in_req  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  acs_pkg::t_out_req i_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending
);

    // shadow registers and cipher state
    logic [63:0]  key_w [4];
    logic [1:0]   key_len;
    logic [63:0]  nonce_r;
    logic [63:0]  offset_run;
    logic [127:0] fb_block;
    int           blk_count;
    logic [7:0]   rkey [240];
    int           n_rounds;
    acs_pkg::t_out_req expected_blocks [$];

    assign o_pending = expected_blocks.size();

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // key schedule into the byte array rkey
    function automatic void build_round_keys();
        int nk, total;
        logic [7:0] rc, t0, tmp [4];
        rc = 8'h01;
        nk = (key_len == acs_pkg::KLEN_128) ? 4 : (key_len == acs_pkg::KLEN_256) ? 8 : 6;
        n_rounds = nk + 6;
        total = 4 * (n_rounds + 1);
        for (int i = 0; i < 4 * nk; i++) rkey[i] = key_w[i >> 3][8 * (i & 7) +: 8];
        for (int i = nk; i < total; i++) begin
            for (int j = 0; j < 4; j++) tmp[j] = rkey[4 * (i - 1) + j];
            if (i % nk == 0) begin
                t0 = tmp[0];
                tmp[0] = tmp[1]; tmp[1] = tmp[2]; tmp[2] = tmp[3]; tmp[3] = t0;
                for (int j = 0; j < 4; j++) tmp[j] = acs_pkg::SBOX[tmp[j]];
                tmp[0] ^= rc;
                rc = gf_dbl(rc);
            end else if (nk > 6 && i % nk == 4) begin
                for (int j = 0; j < 4; j++) tmp[j] = acs_pkg::SBOX[tmp[j]];
            end
            for (int j = 0; j < 4; j++) rkey[4 * i + j] = rkey[4 * (i - nk) + j] ^ tmp[j];
        end
    endfunction

    // forward cipher, byte i at bits 8i+7:8i
    function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
        logic [7:0] st [16], sb [16], a0, a1, a2, a3, x;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) st[i] = blk[8 * i +: 8] ^ rkey[i];
        for (int r = 1; r <= n_rounds; r++) begin
            for (int i = 0; i < 16; i++) sb[i] = acs_pkg::SBOX[st[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) st[i + 4 * c] = sb[i + 4 * ((c + i) & 3)];
            if (r != n_rounds) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4 * c]; a1 = st[4 * c + 1]; a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ x ^ gf_dbl(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rkey[16 * r + i];
        end
        for (int i = 0; i < 16; i++) res[8 * i +: 8] = st[i];
        return res;
    endfunction

    // one request in, one expected block out
    function automatic acs_pkg::t_out_req predict_block(input acs_pkg::t_in_req rq);
        int sect;
        logic [127:0] din, ks, dout;
        acs_pkg::t_out_req ob;
        sect = (SECTOR_BYTES / 16 > 0) ? SECTOR_BYTES / 16 : 1;
        din = {rq.data_hi, rq.data_lo};
        if (rq.start_req || blk_count >= sect) begin
            fb_block = {offset_run, nonce_r};
            offset_run += 64'(SECTOR_BYTES);
            blk_count = 0;
        end
        ks = encrypt_block(fb_block);
        dout = din ^ ks;
        fb_block = rq.mode ? din : dout;
        blk_count++;
        ob.result_lo = dout[63:0];
        ob.result_hi = dout[127:64];
        return ob;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        acs_pkg::t_out_req want;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_w[i] = '0;
            key_len = acs_pkg::KLEN_128;
            nonce_r = '0;
            offset_run = '0;
            fb_block = '0;
            blk_count = 0;
            expected_blocks.delete();
            build_round_keys();
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    acs_pkg::REG_KEY0, acs_pkg::REG_KEY1,
                    acs_pkg::REG_KEY2, acs_pkg::REG_KEY3: begin
                        key_w[paddr[4:3]] = pwdata;
                        build_round_keys();
                    end
                    acs_pkg::REG_KLEN: begin
                        key_len = pwdata[1:0];
                        build_round_keys();
                    end
                    acs_pkg::REG_NONCE:  nonce_r = pwdata;
                    acs_pkg::REG_OFFSET: offset_run = pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) expected_blocks.push_back(predict_block(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("unexpected result", i_out_data.result_lo, '0);
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_out_data.result_lo !== want.result_lo)
                        report_mismatch("result_lo", i_out_data.result_lo, want.result_lo);
                    if (i_out_data.result_hi !== want.result_hi)
                        report_mismatch("result_hi", i_out_data.result_hi, want.result_hi);
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the AES-CFB sector cipher: clock, reset, APB writes and
// random request traffic. Depends on acs_pkg, the block and tb_cfb_checker.
`timescale 1ns / 1ps

module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    acs_pkg::t_in_req  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    acs_pkg::t_out_req out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    logic        in_stall_s = 1'b1;
    bit          quiet = 1'b0;
    bit          long_hold_req = 1'b0;

    aes_cfb_sector_cipher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_cfb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stall sampled mid-cycle, used at the next rising edge
    always @(negedge i_clk) in_stall_s <= in_stall;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 300000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold-off
    initial begin
        int gap;
        int hold;
        gap = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // offer one request and hold it until accepted
    task automatic send_block(input logic md, input logic st, input logic [63:0] lo,
                              input logic [63:0] hi);
        acs_pkg::t_in_req rq;
        rq.mode = md;
        rq.start_req = st;
        rq.data_lo = lo;
        rq.data_hi = hi;
        in_valid <= 1'b1;
        in_data <= rq;
        do @(posedge i_clk); while (in_stall_s);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // buffers of random length, each opened with a start request
    task automatic random_buffers(input int n_items);
        int left, len;
        logic md;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            md = 1'($urandom_range(0, 1));
            for (int i = 0; i < len && left > 0; i++) begin
                if ($urandom_range(0, 15) == 0) md = ~md;
                send_block(md, (i == 0) || ($urandom_range(0, 40) == 0), rand64(), rand64());
                left--;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: no start after reset, then field extremes and both modes
        send_block(1'b0, 1'b0, '0, '0);
        send_block(1'b1, 1'b0, '1, '1);
        send_block(1'b0, 1'b1, '0, '0);
        send_block(1'b0, 1'b0, '1, '0);
        send_block(1'b1, 1'b0, '0, '1);
        send_block(1'b1, 1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(1'b0, 1'b1, '1, '1);
        wait_idle();

        // key length code 3 and the unknown register index
        reg_write(acs_pkg::REG_KEY0, 64'h0706050403020100);
        reg_write(acs_pkg::REG_KEY1, 64'h0f0e0d0c0b0a0908);
        reg_write(acs_pkg::REG_KEY2, 64'h1716151413121110);
        reg_write(acs_pkg::REG_KEY3, 64'h1f1e1d1c1b1a1918);
        reg_write(acs_pkg::REG_KLEN, 64'd3);
        reg_write(3'd7, '1);
        reg_write(acs_pkg::REG_NONCE, '1);
        reg_write(acs_pkg::REG_OFFSET, 64'hffff_ffff_ffff_fc00);   // wraps after two sectors
        for (int i = 0; i < 18; i++) send_block(i[0], i == 0 || i == 9, rand64(), rand64());
        random_buffers(150);
        wait_idle();

        // phases over key sizes and IV settings
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(acs_pkg::REG_KEY0, rand64());
            reg_write(acs_pkg::REG_KEY1, rand64());
            reg_write(acs_pkg::REG_KEY2, rand64());
            reg_write(acs_pkg::REG_KEY3, rand64());
            reg_write(acs_pkg::REG_KLEN, 64'(ph % 3));
            reg_write(acs_pkg::REG_NONCE, (ph == 1) ? '0 : rand64());
            reg_write(acs_pkg::REG_OFFSET, (ph == 2) ? '1 : (ph == 3) ? '0 : rand64());
            if (ph == 2) long_hold_req = 1'b1;
            if (ph == 5) quiet = 1'b1;
            random_buffers(200);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/acs_pkg.sv
hw/rtl/acs_key_expand.sv
hw/rtl/acs_aes_core.sv
hw/rtl/aes_cfb_sector_cipher.sv
tb/sv/tb_cfb_checker.sv
tb/sv/tb_top.sv
